/* src/saa_pkg.sv */
// Shared types, codes and defaults for the skyline atlas allocator.
`default_nettype none

package saa_pkg;

  localparam int MODE_W = 2;
  localparam int DIM_W  = 8;
  localparam int ATL_W  = 4;
  localparam int POS_W  = 8;
  localparam int COL_W  = 9;

  // One border pixel on each side of a picture.
  localparam int BORDER_TOTAL = 2;

  localparam int NUM_ATLASES_DEF  = 2;
  localparam int ATLAS_WIDTH_DEF  = 256;
  localparam int ATLAS_HEIGHT_DEF = 256;

  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DIM_W-1:0]  rect_width;
    logic [DIM_W-1:0]  rect_height;
    logic [ATL_W-1:0]  atlas_select;
  } saa_req_t;

  typedef struct packed {
    logic             ok;
    logic [ATL_W-1:0] atlas_index;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
  } saa_res_t;

endpackage

`default_nettype wire

/* src/saa_ifs.sv */
// Request and result channel interfaces of the skyline atlas allocator.
`default_nettype none

interface saa_in_if import saa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [DIM_W-1:0]  rect_width;
  logic [DIM_W-1:0]  rect_height;
  logic [ATL_W-1:0]  atlas_select;

  modport source (output valid, mode, rect_width, rect_height, atlas_select, input ready);
  modport sink (input valid, mode, rect_width, rect_height, atlas_select, output ready);
endinterface

interface saa_out_if import saa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             ok;
  logic [ATL_W-1:0] atlas_index;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;

  modport source (output valid, ok, atlas_index, pos_x, pos_y, input ready);
  modport sink (input valid, ok, atlas_index, pos_x, pos_y, output ready);
endinterface

`default_nettype wire

/* src/saa_ram.sv */
// Simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module saa_ram import saa_pkg::*; #(
  parameter int DEPTH  = ATLAS_WIDTH_DEF,
  parameter int DATA_W = COL_W,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/saa_ctrl.sv */
// Sequencer and shared max/compare datapath for the skyline scan and update.
`default_nettype none

module saa_ctrl import saa_pkg::*; #(
  parameter int NUM_ATLASES  = NUM_ATLASES_DEF,
  parameter int ATLAS_WIDTH  = ATLAS_WIDTH_DEF,
  parameter int ATLAS_HEIGHT = ATLAS_HEIGHT_DEF,
  localparam int CW     = $clog2(ATLAS_WIDTH),
  localparam int ADDR_W = $clog2(NUM_ATLASES * ATLAS_WIDTH)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              req_valid,
  input  wire saa_req_t          req,
  output logic                   req_ready,
  output logic                   res_valid,
  output saa_res_t               res,
  input  wire logic              res_ready,
  output logic                   col_we,
  output logic      [ADDR_W-1:0] col_waddr,
  output logic      [COL_W-1:0]  col_wdata,
  output logic                   col_re,
  output logic      [ADDR_W-1:0] col_raddr,
  input  wire logic [COL_W-1:0]  col_rdata,
  output logic                   scr_we,
  output logic      [CW-1:0]     scr_waddr,
  output logic      [COL_W-1:0]  scr_wdata,
  output logic                   scr_re,
  output logic      [CW-1:0]     scr_raddr,
  input  wire logic [COL_W-1:0]  scr_rdata
);

  localparam int AIDX_W = (NUM_ATLASES > 1) ? $clog2(NUM_ATLASES) : 1;
  localparam logic [COL_W-1:0]  HGT       = COL_W'(ATLAS_HEIGHT);
  localparam logic [CW-1:0]     LAST_COL  = CW'(ATLAS_WIDTH - 1);
  localparam logic [AIDX_W-1:0] LAST_ATL  = AIDX_W'(NUM_ATLASES - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_ATLASES * ATLAS_WIDTH - 1);
  localparam logic [ADDR_W-1:0] ATL_STEP  = ADDR_W'(ATLAS_WIDTH);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FWD,
    S_REV,
    S_REVW,
    S_EVAL,
    S_RAISE,
    S_REPLY
  } state_t;

  function automatic logic [COL_W-1:0] hmax(input logic [COL_W-1:0] a,
                                            input logic [COL_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic              clr_reply_r, clr_reply_nxt;
  logic              fv_r, fv_nxt;
  logic              rv_r, rv_nxt;
  logic              first_r, first_nxt;
  logic              rin_r, rin_nxt;
  logic [NUM_ATLASES-1:0] dirty_r, dirty_nxt;
  logic [COL_W-1:0]  pw_r, pw_nxt;
  logic [COL_W-1:0]  ph_r, ph_nxt;
  logic [AIDX_W-1:0] atl_r, atl_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [CW-1:0]     dpos_r, dpos_nxt;
  logic [COL_W-1:0]  c_r, c_nxt;
  logic [COL_W-1:0]  run_r, run_nxt;
  logic [COL_W-1:0]  best_r, best_nxt;
  logic [CW-1:0]     bx_r, bx_nxt;
  logic [COL_W-1:0]  rj_r, rj_nxt;
  saa_res_t          res_r, res_nxt;

  logic [9:0]        rev_sum;
  logic [9:0]        fit_sum;
  logic [9:0]        req_pw;
  logic [COL_W-1:0]  wm;

  // Window end for the start column being issued in the reverse pass.
  assign rev_sum = 10'(pos_r) + 10'(pw_r);
  assign fit_sum = 10'(best_r) + 10'(ph_r);
  assign req_pw  = 10'(req.rect_width) + 10'(BORDER_TOTAL);

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_REPLY);
  assign res       = res_r;

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    clr_reply_nxt = clr_reply_r;
    fv_nxt        = 1'b0;
    rv_nxt        = 1'b0;
    first_nxt     = first_r;
    rin_nxt       = 1'b0;
    dirty_nxt     = dirty_r;
    pw_nxt        = pw_r;
    ph_nxt        = ph_r;
    atl_nxt       = atl_r;
    base_nxt      = base_r;
    pos_nxt       = pos_r;
    dpos_nxt      = pos_r;
    c_nxt         = c_r;
    run_nxt       = run_r;
    best_nxt      = best_r;
    bx_nxt        = bx_r;
    rj_nxt        = rj_r;
    res_nxt       = res_r;
    wm            = '0;

    col_we    = 1'b0;
    col_waddr = clr_addr_r;
    col_wdata = '0;
    col_re    = 1'b0;
    col_raddr = base_r + ADDR_W'(pos_r);
    scr_we    = 1'b0;
    scr_waddr = dpos_r;
    scr_wdata = run_nxt;
    scr_re    = 1'b0;
    scr_raddr = CW'(rev_sum - 10'd1);

    // Forward pass: running maximum from the start of each block of pw columns.
    if (fv_r) begin
      run_nxt   = (c_r == '0) ? col_rdata : hmax(run_r, col_rdata);
      scr_we    = 1'b1;
      scr_wdata = run_nxt;
      // The counter is kept at the last column so the reverse pass starts in phase.
      if (dpos_r != LAST_COL) begin
        c_nxt = (c_r == pw_r - 9'd1) ? '0 : c_r + 9'd1;
      end
    end

    // Reverse pass: running maximum to the end of each block, joined with the
    // stored prefix maximum at the window end to give the window maximum.
    if (rv_r) begin
      run_nxt   = (first_r || (c_r == pw_r - 9'd1)) ? col_rdata : hmax(run_r, col_rdata);
      first_nxt = 1'b0;
      c_nxt     = (c_r == '0) ? pw_r - 9'd1 : c_r - 9'd1;
      wm        = hmax(run_nxt, scr_rdata);
      // Ties move the choice left, since the pass runs right to left.
      if (rin_r && (wm <= best_r) && (wm < HGT)) begin
        best_nxt = wm;
        bx_nxt   = dpos_r;
      end
    end

    case (state_r)
      S_CLEAR: begin
        col_we       = 1'b1;
        col_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == LAST_ADDR) begin
          clr_addr_nxt = '0;
          state_nxt    = clr_reply_r ? S_REPLY : S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          res_nxt = '0;
          case (req.mode)
            MODE_ALLOC: begin
              pw_nxt   = COL_W'(req_pw);
              ph_nxt   = COL_W'(req.rect_height) + COL_W'(BORDER_TOTAL);
              atl_nxt  = '0;
              base_nxt = '0;
              pos_nxt  = '0;
              c_nxt    = '0;
              best_nxt = HGT;
              bx_nxt   = '0;
              // A padded width that leaves no start column fails at once.
              state_nxt = (req_pw >= 10'(ATLAS_WIDTH)) ? S_REPLY : S_FWD;
            end
            MODE_QUERY: begin
              res_nxt.atlas_index = req.atlas_select;
              if (5'(req.atlas_select) < 5'(NUM_ATLASES)) begin
                res_nxt.ok = dirty_r[AIDX_W'(req.atlas_select)];
                dirty_nxt[AIDX_W'(req.atlas_select)] = 1'b0;
              end
              state_nxt = S_REPLY;
            end
            MODE_CLEAR: begin
              res_nxt.ok    = 1'b1;
              dirty_nxt     = '0;
              clr_addr_nxt  = '0;
              clr_reply_nxt = 1'b1;
              state_nxt     = S_CLEAR;
            end
            default: begin
              state_nxt = S_REPLY;
            end
          endcase
        end
      end
      S_FWD: begin
        col_re  = 1'b1;
        fv_nxt  = 1'b1;
        pos_nxt = pos_r + CW'(1);
        if (pos_r == LAST_COL) begin
          pos_nxt   = LAST_COL;
          first_nxt = 1'b1;
          state_nxt = S_REV;
        end
      end
      S_REV: begin
        col_re  = 1'b1;
        rv_nxt  = 1'b1;
        rin_nxt = (rev_sum < 10'(ATLAS_WIDTH));
        scr_re  = rin_nxt;
        pos_nxt = pos_r - CW'(1);
        if (pos_r == '0) begin
          state_nxt = S_REVW;
        end
      end
      S_REVW: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (fit_sum <= 10'(ATLAS_HEIGHT)) begin
          rj_nxt         = '0;
          dirty_nxt[atl_r] = 1'b1;
          state_nxt      = S_RAISE;
        end else if (atl_r == LAST_ATL) begin
          res_nxt   = '0;
          state_nxt = S_REPLY;
        end else begin
          atl_nxt   = atl_r + AIDX_W'(1);
          base_nxt  = base_r + ATL_STEP;
          pos_nxt   = '0;
          c_nxt     = '0;
          best_nxt  = HGT;
          bx_nxt    = '0;
          state_nxt = S_FWD;
        end
      end
      S_RAISE: begin
        col_we    = 1'b1;
        col_waddr = base_r + ADDR_W'(bx_r) + ADDR_W'(rj_r);
        col_wdata = COL_W'(fit_sum);
        rj_nxt    = rj_r + 9'd1;
        if (rj_r == pw_r - 9'd1) begin
          res_nxt.ok          = 1'b1;
          res_nxt.atlas_index = ATL_W'(atl_r);
          res_nxt.pos_x       = POS_W'(bx_r) + POS_W'(1);
          res_nxt.pos_y       = POS_W'(best_r) + POS_W'(1);
          state_nxt           = S_REPLY;
        end
      end
      S_REPLY: begin
        if (res_ready) begin
          clr_reply_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    pw_r   <= pw_nxt;
    ph_r   <= ph_nxt;
    atl_r  <= atl_nxt;
    base_r <= base_nxt;
    pos_r  <= pos_nxt;
    dpos_r <= dpos_nxt;
    c_r    <= c_nxt;
    run_r  <= run_nxt;
    best_r <= best_nxt;
    bx_r   <= bx_nxt;
    rj_r   <= rj_nxt;
    res_r  <= res_nxt;
    rin_r  <= rin_nxt;
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      clr_reply_r <= 1'b0;
      fv_r        <= 1'b0;
      rv_r        <= 1'b0;
      first_r     <= 1'b0;
      dirty_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_reply_r <= clr_reply_nxt;
      fv_r        <= fv_nxt;
      rv_r        <= rv_nxt;
      first_r     <= first_nxt;
      dirty_r     <= dirty_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/skyline_atlas_allocator_core.sv */
// Top level of the skyline atlas allocator: memories, sequencer and result register.
//
// Requests arrive on in_ch (valid/ready); each request yields exactly one result word
// on out_ch. A word is taken at a rising edge where valid and ready are both high.
// Allocate scans the skyline of each atlas in turn, one column per cycle through the
// column memory port: a forward pass over the ATLAS_WIDTH columns, a reverse pass
// over them again, then a wait state and an evaluation state to decide for each atlas
// tried; then the chosen columns, as many as the padded width, are raised one by one
// and the result is handed over. A padded width that leaves no start column, a query
// or an unused mode answers without a scan. A clear request sweeps the column memory,
// all NUM_ATLASES*ATLAS_WIDTH words, then answers.
// After reset the same sweep runs once with in_ch.ready low.
// One request is worked on at a time; in_ch.ready is high only while the sequencer
// is idle. A finished result sits in an output register, so the next request can be
// taken while the receiver stalls; that request's result then waits until the
// register has been emptied.
`default_nettype none

module skyline_atlas_allocator_core import saa_pkg::*; #(
  parameter int NUM_ATLASES  = NUM_ATLASES_DEF,
  parameter int ATLAS_WIDTH  = ATLAS_WIDTH_DEF,
  parameter int ATLAS_HEIGHT = ATLAS_HEIGHT_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  saa_in_if.sink   in_ch,
  saa_out_if.source out_ch
);

  localparam int CW     = $clog2(ATLAS_WIDTH);
  localparam int ADDR_W = $clog2(NUM_ATLASES * ATLAS_WIDTH);

  saa_req_t          req;
  logic              req_ready;
  logic              res_valid;
  logic              res_ready;
  saa_res_t          res;
  logic              col_we, col_re;
  logic [ADDR_W-1:0] col_waddr, col_raddr;
  logic [COL_W-1:0]  col_wdata, col_rdata;
  logic              scr_we, scr_re;
  logic [CW-1:0]     scr_waddr, scr_raddr;
  logic [COL_W-1:0]  scr_wdata, scr_rdata;
  logic              out_valid_r;
  saa_res_t          out_res_r;

  assign req.mode         = in_ch.mode;
  assign req.rect_width   = in_ch.rect_width;
  assign req.rect_height  = in_ch.rect_height;
  assign req.atlas_select = in_ch.atlas_select;
  assign in_ch.ready      = req_ready;

  // The result register takes a new word when it is empty or being emptied.
  assign res_ready = !out_valid_r || out_ch.ready;

  saa_ctrl #(
    .NUM_ATLASES  (NUM_ATLASES),
    .ATLAS_WIDTH  (ATLAS_WIDTH),
    .ATLAS_HEIGHT (ATLAS_HEIGHT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_ch.valid),
    .req       (req),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .col_we    (col_we),
    .col_waddr (col_waddr),
    .col_wdata (col_wdata),
    .col_re    (col_re),
    .col_raddr (col_raddr),
    .col_rdata (col_rdata),
    .scr_we    (scr_we),
    .scr_waddr (scr_waddr),
    .scr_wdata (scr_wdata),
    .scr_re    (scr_re),
    .scr_raddr (scr_raddr),
    .scr_rdata (scr_rdata)
  );

  saa_ram #(
    .DEPTH  (NUM_ATLASES * ATLAS_WIDTH),
    .DATA_W (COL_W)
  ) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (col_waddr),
    .wdata (col_wdata),
    .re    (col_re),
    .raddr (col_raddr),
    .rdata (col_rdata)
  );

  saa_ram #(
    .DEPTH  (ATLAS_WIDTH),
    .DATA_W (COL_W)
  ) u_scr_ram (
    .clk   (clk),
    .we    (scr_we),
    .waddr (scr_waddr),
    .wdata (scr_wdata),
    .re    (scr_re),
    .raddr (scr_raddr),
    .rdata (scr_rdata)
  );

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.ok          = out_res_r.ok;
  assign out_ch.atlas_index = out_res_r.atlas_index;
  assign out_ch.pos_x       = out_res_r.pos_x;
  assign out_ch.pos_y       = out_res_r.pos_y;

endmodule

`default_nettype wire
